// File: src/ogn_pkg.sv
package ogn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int TABLE_ENTRIES   = 256;
    localparam int HALF_ROM        = 128;

    // datapath widths, sized for the largest octave count of sixteen
    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int CELL_W  = 8;
    localparam int S_W     = 17;
    localparam int GRAD_W  = 16;
    localparam int DOT_W   = 36;
    localparam int V_W     = 21;
    localparam int SUM_W   = 43;
    localparam int WSUM_W  = 21;
    localparam int F_W     = 37;
    localparam int DVD_W   = 60;
    localparam int Q_W     = 16;

    localparam int ONE_Q16        = 65536;
    localparam int SQRT3_HALF_Q16 = 56756;

    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef t_grad t_grad_tab [TABLE_ENTRIES];
    typedef int t_dec_tab [HALF_ROM];

    localparam t_dec_tab ROM_X = '{
        513,-1160,-1404,1475,2168,-1424,-2865,1119,3471,
        -614,-3955,-50,4289,832,-4450,-1690,4423,2583,
        -4200,-3468,3782,4302,-3178,-5045,2403,5660,-1482,
        -6116,444,6385,676,-6449,-1837,6296,2999,-5921,
        -4118,5329,5152,-4534,-6061,3556,6808,-2422,-7361,
        1167,7694,170,-7791,-1545,7639,2914,-7238,-4230,
        6593,5447,-5721,-6523,4645,7419,-3395,-8101,2008,
        8543,-528,-8724,-1000,8634,2526,-8270,-4001,7641,
        5377,-6761,-6608,5654,7652,-4354,-8472,2899,9039,
        -1332,-9332,-296,9338,1935,-9053,-3534,8484,5040,
        -7644,-6405,6559,7585,-5259,-8540,3785,9238,-2182,
        -9655,499,9777,1212,-9596,-2896,9118,4501,-8354,
        -5975,7329,7272,-6072,-8349,4622,9173,-3025,-9717,
        1329,9962,412,-9900,-2144,9533,3813,-8871,-5366,
        7935,6755
    };

    localparam t_dec_tab ROM_Y = '{
        -719,-992,1377,1794,-1486,-2526,1299,3182,-888,
        -3730,299,4142,429,-4392,-1254,4460,2135,-4336,
        -3029,4015,3894,-3503,-4687,2810,5371,-1959,-5910,
        975,6275,108,-6444,-1254,6400,2421,-6136,-3567,
        5652,4648,-4956,-5625,4066,6457,-3006,-7110,1807,
        7556,-506,-7773,-855,7746,2233,-7469,-3581,6945,
        4854,-6184,-6006,5207,6996,-4039,-7789,2716,8354,
        -1277,-8667,-233,8713,1766,-8486,-3273,7988,4705,
        -7231,-6014,6234,7156,-5026,-8092,3643,8789,-2126,
        -9221,523,9372,1118,-9232,-2743,8803,4302,-8096,
        -5743,7130,7021,-5933,-8093,4542,8923,-2997,-9483,
        1347,9754,357,-9724,-2061,9394,3712,-8770,-5257,
        7873,6648,-6727,-7840,5369,8795,-3839,-9481,2186,
        9877,-461,-9969,-1283,9754,2990,-9238,-4607,8436,
        6084,-7374
    };

    // ten-thousandths to q1.14, round to nearest
    function automatic int dec_to_q14(int v);
        int r;
        if (v >= 0) begin
            r = (v * 2048 + 625) / 1250;
        end else begin
            r = -(((-v) * 2048 + 625) / 1250);
        end
        return r;
    endfunction

    function automatic t_grad_tab build_grad(int axis);
        t_grad_tab tab;
        int g;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (axis == 0) begin
                g = (k < HALF_ROM) ? dec_to_q14(ROM_X[k]) : -dec_to_q14(ROM_X[255 - k]);
            end else if (axis == 1) begin
                g = (k < HALF_ROM) ? dec_to_q14(ROM_Y[k]) : dec_to_q14(ROM_Y[255 - k]);
            end else begin
                g = (2 * k - 255) * 64;
            end
            tab[k] = GRAD_W'(g);
        end
        return tab;
    endfunction

    localparam t_grad_tab GRAD_X = build_grad(0);
    localparam t_grad_tab GRAD_Y = build_grad(1);
    localparam t_grad_tab GRAD_Z = build_grad(2);

endpackage

// File: src/ogn_ram.sv
module ogn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ogn_div.sv
module ogn_div
    import ogn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [F_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    // restoring division, one quotient bit a cycle, saturating at all ones
    logic                     r_run;
    logic                     r_done;
    logic [DVD_W-1:0]         r_rem;
    logic [DVD_W-1:0]         r_dsh;
    logic [Q_W-1:0]           r_q;
    logic [$clog2(Q_W)-1:0]   r_cnt;
    logic [DVD_W-1:0]         lim;
    logic                     fits;

    assign lim  = DVD_W'(i_divisor) << Q_W;
    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_dividend;
                r_dsh <= DVD_W'(i_divisor) << (Q_W - 1);
                r_cnt <= '0;
                if (i_dividend >= lim) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_q   <= '0;
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (fits) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[Q_W-2:0], fits};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(Q_W))'(Q_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/octave_gradient_noise_3d_unit.sv
// per evaluation: setup, one pass per octave, then weight scaling and
//   final division
// throughput: one evaluate beat at a time, set by the chained permutation
//   memory reads (three per corner, eight corners per octave) and the
//   16-step quotient unit; table writes never set busy
// reset: synchronous, active low; clears control and configuration only,
//   tables are undefined until written; the receiver cannot stall results
module octave_gradient_noise_3d_unit
    import ogn_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [10:0] i_table_index,
    input  logic [31:0] i_table_value,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    // result strobe
    output logic        o_valid,
    output logic [15:0] o_noise_value,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int PDEPTH  = MAX_OCTAVES * TABLE_ENTRIES;
    localparam int PADDR_W = $clog2(PDEPTH);
    localparam int ODEPTH  = MAX_OCTAVES * 3;
    localparam int OADDR_W = $clog2(ODEPTH);
    localparam int OCT_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);

    localparam logic [1:0] K_PERM = 2'd0;
    localparam logic [1:0] K_OFFS = 2'd1;
    localparam logic [1:0] K_EVAL = 2'd2;

    localparam logic       CFG_COUNT = 1'b0;
    localparam logic       CFG_FADE  = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] LV_X = 2'd0;
    localparam logic [1:0] LV_Y = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_OFF_REQ, S_OFF_DAT, S_F1, S_F2, S_F3, S_F4,
        S_C_A, S_C_B, S_C_C, S_C_H, S_D_X, S_D_Y, S_D_Z, S_D_V,
        S_L_MUL, S_L_ADD, S_ACC1, S_ACC2, S_ACC3, S_FIN1, S_FIN2, S_DIV
    } t_state;

    t_state r_state;

    // configuration registers
    logic [3:0]  r_oct_count;
    logic [16:0] r_fade;

    // per-point and per-octave state
    logic [COORD_W-1:0]      r_cx, r_cy, r_cz;
    logic [CNT_W-1:0]        r_oct, r_cnt;
    logic [OADDR_W-1:0]      r_off_base;
    logic [1:0]              r_ax;
    logic [CELL_W-1:0]       r_cell_x, r_cell_y, r_cell_z;
    logic [FRAC_W-1:0]       r_fx, r_fy, r_fz;
    logic [FRAC_W-1:0]       r_t;
    logic [31:0]             r_tt;
    logic [32:0]             r_t3p;
    logic [19:0]             r_inner;
    logic [36:0]             r_sp;
    logic [S_W-1:0]          r_sx, r_sy, r_sz;
    logic [2:0]              r_c;
    logic signed [GRAD_W-1:0] r_gx, r_gy, r_gz;
    logic signed [DOT_W-1:0] r_dot;
    logic signed [V_W-1:0]   r_hold0, r_hold1, r_hold2;
    logic signed [V_W-1:0]   r_la, r_lb, r_noise;
    logic [1:0]              r_lvl;
    logic signed [39:0]      r_lprod;
    logic signed [38:0]      r_aprod;
    logic [S_W-1:0]          r_w;
    logic [33:0]             r_wprod;
    logic signed [SUM_W-1:0] r_sum;
    logic [WSUM_W-1:0]       r_wsum;
    logic [F_W-1:0]          r_f;
    logic                    r_div_start;
    logic [DVD_W-1:0]        r_dividend;
    logic                    r_valid;
    logic [Q_W-1:0]          r_noise_out;

    // memory ports
    logic               accept;
    logic               perm_we, offs_we;
    logic [PADDR_W-1:0] perm_raddr;
    logic [7:0]         perm_rdata;
    logic [OADDR_W-1:0] offs_raddr;
    logic [31:0]        offs_rdata;
    logic [CELL_W-1:0]  perm_entry;

    // arithmetic
    logic [COORD_W-1:0]      coord_cur, pos;
    logic [16:0]             t2, t3;
    logic [35:0]             six_tt;
    logic [19:0]             inner_c;
    logic [20:0]             s_raw;
    logic [S_W-1:0]          s_fade;
    logic signed [17:0]      dterm;
    logic signed [GRAD_W-1:0] gsel;
    logic signed [33:0]      dprod;
    logic signed [V_W-1:0]   v_new;
    logic [S_W-1:0]          s_sel;
    logic signed [21:0]      ldiff;
    logic signed [39:0]      lrnd;
    logic signed [V_W-1:0]   lres;
    logic [S_W-1:0]          fw;
    logic signed [SUM_W:0]   num;
    logic [CNT_W-1:0]        cnt_eff;
    logic                    div_done;
    logic [Q_W-1:0]          div_quot;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // table writes land in the accept cycle itself
    assign perm_we = accept && (i_kind == K_PERM) && (32'(i_table_index) < PDEPTH);
    assign offs_we = accept && (i_kind == K_OFFS) && (32'(i_table_index) < ODEPTH);

    // octave count clamped to 1..MAX_OCTAVES, weight factor clamped to 1.0
    assign cnt_eff = (r_oct_count == 4'd0) ? CNT_W'(1) :
                     (32'(r_oct_count) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES) :
                     CNT_W'(r_oct_count);
    assign fw = (32'(r_fade) > ONE_Q16) ? S_W'(ONE_Q16) : r_fade;

    // three chained hash reads per corner: z first, then y, then x
    always_comb begin
        case (r_state)
            S_C_A:   perm_entry = r_cell_z + CELL_W'(r_c[2]);
            S_C_B:   perm_entry = (r_cell_y + CELL_W'(r_c[1])) ^ perm_rdata;
            S_C_C:   perm_entry = (r_cell_x + CELL_W'(r_c[0])) ^ perm_rdata;
            default: perm_entry = '0;
        endcase
    end
    assign perm_raddr = PADDR_W'({r_oct[OCT_W-1:0], perm_entry});
    assign offs_raddr = r_off_base + OADDR_W'(r_ax);

    // lattice position of the current axis, only the low 24 bits matter
    always_comb begin
        case (r_ax)
            AX_X:    coord_cur = r_cx;
            AX_Y:    coord_cur = r_cy;
            default: coord_cur = r_cz;
        endcase
    end
    assign pos = coord_cur - offs_rdata[COORD_W-1:0];

    // quintic fade pieces
    assign t2      = 17'((33'(r_tt) + 33'd32768) >> 16);
    assign six_tt  = 36'(r_tt) * 36'd6;
    assign inner_c = 20'(36'd655360 - 36'(r_t) * 36'd15 + ((six_tt + 36'd32768) >> 16));
    assign t3      = 17'((34'(r_t3p) + 34'd32768) >> 16);
    assign s_raw   = 21'((38'(r_sp) + 38'd32768) >> 16);
    assign s_fade  = (s_raw > 21'(ONE_Q16)) ? S_W'(ONE_Q16) : S_W'(s_raw);

    // corner-to-point times gradient, one axis a cycle
    always_comb begin
        case (r_state)
            S_D_X: begin
                dterm = $signed({2'b00, r_fx}) - (r_c[0] ? 18'sd65536 : 18'sd0);
                gsel  = r_gx;
            end
            S_D_Y: begin
                dterm = $signed({2'b00, r_fy}) - (r_c[1] ? 18'sd65536 : 18'sd0);
                gsel  = r_gy;
            end
            default: begin
                dterm = $signed({2'b00, r_fz}) - (r_c[2] ? 18'sd65536 : 18'sd0);
                gsel  = r_gz;
            end
        endcase
    end
    assign dprod = dterm * gsel;
    assign v_new = V_W'((r_dot + 36'sd8192) >>> 14);

    // shared lerp: a + floor((s * (b - a) + half) / 2^16)
    always_comb begin
        case (r_lvl)
            LV_X:    s_sel = r_sx;
            LV_Y:    s_sel = r_sy;
            default: s_sel = r_sz;
        endcase
    end
    assign ldiff = 22'(r_lb) - 22'(r_la);
    assign lrnd  = (r_lprod + 40'sd32768) >>> 16;
    assign lres  = r_la + V_W'(lrnd);

    assign num = (SUM_W + 1)'(r_sum) + $signed({1'b0, (SUM_W)'(r_f)});

    ogn_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (PADDR_W'(i_table_index)),
        .i_wdata (i_table_value[7:0]),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    ogn_ram #(.WIDTH(32), .DEPTH(ODEPTH)) u_offs_ram (
        .i_clk   (i_clk),
        .i_we    (offs_we),
        .i_waddr (OADDR_W'(i_table_index)),
        .i_wdata (i_table_value),
        .i_raddr (offs_raddr),
        .o_rdata (offs_rdata)
    );

    ogn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_f),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // configuration port; the user writes it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_count <= 4'd1;
            r_fade      <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUNT: r_oct_count <= i_cfg_data[3:0];
                CFG_FADE:  r_fade      <= i_cfg_data;
                default:   r_fade      <= r_fade;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_kind == K_EVAL) begin
                        r_cx       <= i_coord_x[COORD_W-1:0];
                        r_cy       <= i_coord_y[COORD_W-1:0];
                        r_cz       <= i_coord_z[COORD_W-1:0];
                        r_oct      <= '0;
                        r_cnt      <= cnt_eff;
                        r_off_base <= '0;
                        r_ax       <= AX_X;
                        r_w        <= S_W'(ONE_Q16);
                        r_sum      <= '0;
                        r_wsum     <= '0;
                        r_state    <= S_OFF_REQ;
                    end
                end
                S_OFF_REQ: r_state <= S_OFF_DAT;
                S_OFF_DAT: begin
                    case (r_ax)
                        AX_X: begin
                            r_cell_x <= pos[23:16];
                            r_fx     <= pos[15:0];
                        end
                        AX_Y: begin
                            r_cell_y <= pos[23:16];
                            r_fy     <= pos[15:0];
                        end
                        default: begin
                            r_cell_z <= pos[23:16];
                            r_fz     <= pos[15:0];
                        end
                    endcase
                    r_t     <= pos[15:0];
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_tt    <= 32'(r_t) * 32'(r_t);
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_t3p   <= 33'(t2) * 33'(r_t);
                    r_inner <= inner_c;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_sp    <= 37'(t3) * 37'(r_inner);
                    r_state <= S_F4;
                end
                S_F4: begin
                    case (r_ax)
                        AX_X:    r_sx <= s_fade;
                        AX_Y:    r_sy <= s_fade;
                        default: r_sz <= s_fade;
                    endcase
                    if (r_ax == AX_Z) begin
                        r_c     <= '0;
                        r_state <= S_C_A;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_OFF_REQ;
                    end
                end
                S_C_A: r_state <= S_C_B;
                S_C_B: r_state <= S_C_C;
                S_C_C: r_state <= S_C_H;
                S_C_H: begin
                    r_gx    <= GRAD_X[perm_rdata];
                    r_gy    <= GRAD_Y[perm_rdata];
                    r_gz    <= GRAD_Z[perm_rdata];
                    r_state <= S_D_X;
                end
                S_D_X: begin
                    r_dot   <= DOT_W'(dprod);
                    r_state <= S_D_Y;
                end
                S_D_Y: begin
                    r_dot   <= r_dot + DOT_W'(dprod);
                    r_state <= S_D_Z;
                end
                S_D_Z: begin
                    r_dot   <= r_dot + DOT_W'(dprod);
                    r_state <= S_D_V;
                end
                S_D_V: begin
                    // even corner waits for its partner along x
                    if (!r_c[0]) begin
                        r_hold0 <= v_new;
                        r_c     <= r_c + 3'd1;
                        r_state <= S_C_A;
                    end else begin
                        r_la    <= r_hold0;
                        r_lb    <= v_new;
                        r_lvl   <= LV_X;
                        r_state <= S_L_MUL;
                    end
                end
                S_L_MUL: begin
                    r_lprod <= $signed({1'b0, s_sel}) * ldiff;
                    r_state <= S_L_ADD;
                end
                S_L_ADD: begin
                    case (r_lvl)
                        LV_X: begin
                            if (!r_c[1]) begin
                                r_hold1 <= lres;
                                r_c     <= r_c + 3'd1;
                                r_state <= S_C_A;
                            end else begin
                                r_la    <= r_hold1;
                                r_lb    <= lres;
                                r_lvl   <= LV_Y;
                                r_state <= S_L_MUL;
                            end
                        end
                        LV_Y: begin
                            if (!r_c[2]) begin
                                r_hold2 <= lres;
                                r_c     <= r_c + 3'd1;
                                r_state <= S_C_A;
                            end else begin
                                r_la    <= r_hold2;
                                r_lb    <= lres;
                                r_lvl   <= 2'd2;
                                r_state <= S_L_MUL;
                            end
                        end
                        default: begin
                            r_noise <= lres;
                            r_state <= S_ACC1;
                        end
                    endcase
                end
                S_ACC1: begin
                    r_aprod <= $signed({1'b0, r_w}) * r_noise;
                    r_state <= S_ACC2;
                end
                S_ACC2: begin
                    r_sum   <= r_sum + SUM_W'(r_aprod);
                    r_wsum  <= r_wsum + WSUM_W'(r_w);
                    r_wprod <= 34'(r_w) * 34'(fw);
                    r_state <= S_ACC3;
                end
                S_ACC3: begin
                    r_w <= S_W'((r_wprod + 34'd32768) >> 16);
                    if (r_oct + CNT_W'(1) == r_cnt) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_oct      <= r_oct + CNT_W'(1);
                        r_off_base <= r_off_base + OADDR_W'(3);
                        r_ax       <= AX_X;
                        r_cx       <= r_cx << 1;
                        r_cy       <= r_cy << 1;
                        r_cz       <= r_cz << 1;
                        r_state    <= S_OFF_REQ;
                    end
                end
                S_FIN1: begin
                    r_f     <= F_W'(r_wsum) * F_W'(SQRT3_HALF_Q16);
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    if (num[SUM_W] || num == '0) begin
                        r_noise_out <= '0;
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_dividend  <= (DVD_W'(unsigned'(num)) << 15) + DVD_W'(r_f >> 1);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_noise_out <= div_quot;
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_noise_value = r_noise_out;

    // a result only follows an evaluation in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an evaluation in flight");

    // the result beat frees the command side at once
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy still high in the result beat");

    // an accepted evaluate beat starts the sequencer
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == K_EVAL) |=> busy)
        else $error("evaluate beat accepted but sequencer idle");

    // the divider is only launched from the final step
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV && $past(r_state) == S_FIN2))
        else $error("quotient unit started out of sequence");

endmodule

// File: tb/ogn_tb_pkg.sv
package ogn_tb_pkg;

    // beat kinds on the command channel
    typedef enum logic [1:0] {
        KIND_PERM_WRITE   = 2'd0,
        KIND_OFFSET_WRITE = 2'd1,
        KIND_EVALUATE     = 2'd2,
        KIND_UNUSED       = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic CFG_OCTAVE_COUNT = 1'b0;
    localparam logic CFG_FADE_WEIGHT  = 1'b1;

    localparam int PERM_DEPTH   = 2048;
    localparam int OFFSET_DEPTH = 24;

endpackage

// File: tb/octave_gradient_noise_3d_checker.sv
module octave_gradient_noise_3d_checker
    import ogn_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [10:0] i_table_index,
    input  logic [31:0] i_table_value,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_valid,
    input  logic [15:0] i_noise_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_evaluates,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  perm_tab [PERM_DEPTH];
    logic [31:0] offset_tab [OFFSET_DEPTH];
    logic [3:0]  octaves_cfg;
    logic [16:0] fade_cfg;
    logic [15:0] noise_expected [$];

    assign o_pending = noise_expected.size();

    function automatic longint ten_thousandths_to_q14(longint v);
        if (v >= 0) return (v * 2048 + 625) / 1250;
        return -(((-v) * 2048 + 625) / 1250);
    endfunction

    function automatic longint gradient(int k, int axis);
        if (axis == 0)
            return k < 128 ? ten_thousandths_to_q14(ogn_pkg::ROM_X[k])
                           : -ten_thousandths_to_q14(ogn_pkg::ROM_X[255 - k]);
        if (axis == 1)
            return k < 128 ? ten_thousandths_to_q14(ogn_pkg::ROM_Y[k])
                           : ten_thousandths_to_q14(ogn_pkg::ROM_Y[255 - k]);
        return (2 * k - 255) * 64;
    endfunction

    function automatic longint quintic(longint u);
        longint t, t2, t3, inner, s;
        t = u & 64'hFFFF;
        t2 = (t * t + 32768) >>> 16;
        t3 = (t2 * t + 32768) >>> 16;
        inner = 655360 - 15 * t + ((6 * t * t + 32768) >>> 16);
        s = (t3 * inner + 32768) >>> 16;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic longint blend(longint a, longint b, longint s);
        return a + ((s * (b - a) + 32768) >>> 16);
    endfunction

    function automatic longint octave_sample(int oct, longint pos [3]);
        int lattice [3];
        longint frac [3];
        longint v [8];
        longint dot, sx, sy, sz;
        int h, bx, by, bz;
        for (int a = 0; a < 3; a++) begin
            lattice[a] = int'((pos[a] >>> 16) & 255);
            frac[a] = pos[a] & 64'hFFFF;
        end
        for (int c = 0; c < 8; c++) begin
            bx = c & 1;
            by = (c >> 1) & 1;
            bz = (c >> 2) & 1;
            h = perm_tab[oct * 256 + ((lattice[2] + bz) & 255)];
            h = perm_tab[oct * 256 + (((lattice[1] + by) & 255) ^ h)];
            h = perm_tab[oct * 256 + (((lattice[0] + bx) & 255) ^ h)];
            dot = (frac[0] - bx * 65536) * gradient(h, 0)
                + (frac[1] - by * 65536) * gradient(h, 1)
                + (frac[2] - bz * 65536) * gradient(h, 2);
            v[c] = (dot + 8192) >>> 14;
        end
        sx = quintic(frac[0]);
        sy = quintic(frac[1]);
        sz = quintic(frac[2]);
        return blend(blend(blend(v[0], v[1], sx), blend(v[2], v[3], sx), sy),
                     blend(blend(v[4], v[5], sx), blend(v[6], v[7], sx), sy), sz);
    endfunction

    function automatic logic [15:0] predict_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
        longint pt [3];
        longint pos [3];
        longint fw, w, wsum, sum, f, num, q;
        int count;
        pt[0] = longint'($signed(x));
        pt[1] = longint'($signed(y));
        pt[2] = longint'($signed(z));
        count = octaves_cfg;
        if (count == 0) count = 1;
        if (count > 8) count = 8;
        fw = fade_cfg > 65536 ? 65536 : longint'(fade_cfg);
        w = 65536;
        wsum = 0;
        sum = 0;
        for (int j = 0; j < count; j++) begin
            for (int a = 0; a < 3; a++)
                pos[a] = pt[a] * (longint'(1) << j)
                       - longint'($signed(offset_tab[j * 3 + a]));
            sum += w * octave_sample(j, pos);
            wsum += w;
            w = (w * fw + 32768) >>> 16;
        end
        f = 56756 * wsum;
        num = sum + f;
        if (num <= 0) return 16'd0;
        q = (num * 32768 + f / 2) / f;
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves_cfg <= 4'd1;
            fade_cfg <= 17'd32768;
            noise_expected.delete();
            o_errors <= 0;
            o_evaluates <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OCTAVE_COUNT) octaves_cfg <= i_cfg_data[3:0];
                else fade_cfg <= i_cfg_data;
            end
            if (start && !busy) begin
                case (t_kind'(i_kind))
                    KIND_PERM_WRITE: begin
                        perm_tab[i_table_index] = i_table_value[7:0];
                    end
                    KIND_OFFSET_WRITE: begin
                        if (i_table_index < OFFSET_DEPTH)
                            offset_tab[i_table_index] = i_table_value;
                    end
                    KIND_EVALUATE: begin
                        noise_expected.push_back(predict_noise(i_coord_x, i_coord_y,
                                                               i_coord_z));
                        o_evaluates <= o_evaluates + 1;
                    end
                    default: ;
                endcase
            end
            if (i_valid) begin
                o_results <= o_results + 1;
                if (noise_expected.size() == 0)
                    report_mismatch("unexpected beat", i_noise_value, 16'd0);
                else if (i_noise_value !== noise_expected[0])
                    report_mismatch("noise_value", i_noise_value, noise_expected.pop_front());
                else
                    void'(noise_expected.pop_front());
            end
        end
    end

endmodule

// File: tb/octave_gradient_noise_3d_unit_test.sv
module octave_gradient_noise_3d_unit_test;
    import ogn_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [10:0] i_table_index;
    logic [31:0] i_table_value;
    logic [31:0] i_coord_x;
    logic [31:0] i_coord_y;
    logic [31:0] i_coord_z;
    logic        o_valid;
    logic [15:0] o_noise_value;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;

    int errors, pending, evaluates, results;
    int idle_pct;
    int stall_cycles;
    int beats;

    octave_gradient_noise_3d_unit dut (.*);

    octave_gradient_noise_3d_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_kind, .i_table_index, .i_table_value,
        .i_coord_x, .i_coord_y, .i_coord_z,
        .i_valid(o_valid), .i_noise_value(o_noise_value),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_evaluates(evaluates),
        .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a run of cycles with no beat either way means a hang
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("simulation failed");
            $finish;
        end
    end

    // one command beat; holds start until the block takes it, then maybe idles
    task automatic send_beat(t_kind k, logic [10:0] idx, logic [31:0] val,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        start <= 1'b1;
        i_kind <= k;
        i_table_index <= idx;
        i_table_value <= val;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (busy);
        beats++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic evaluate(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_beat(KIND_EVALUATE, 11'($urandom), $urandom, x, y, z);
    endtask

    // wait for every expected result, then let the block settle
    task automatic quiesce();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (850) @(posedge i_clk);
    endtask

    // only called once the block is quiet
    task automatic write_cfg(logic idx, logic [16:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random coordinate: full range or near the origin, where lattice
    // wrap and small fractions both get exercised
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(2))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return {$urandom_range(0, 15) == 0 ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            evaluate(rand_coord(), rand_coord(), rand_coord());
        end else if (pick < 84) begin
            send_beat(KIND_PERM_WRITE, 11'($urandom), $urandom, $urandom, $urandom,
                      $urandom);
        end else if (pick < 92) begin
            // mostly live offsets, some out of range that must be dropped
            send_beat(KIND_OFFSET_WRITE,
                      $urandom_range(3) == 0 ? 11'($urandom_range(24, 2047))
                                             : 11'($urandom_range(0, 23)),
                      $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_beat(KIND_UNUSED, 11'($urandom), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    logic [3:0]  octave_plan [6];
    logic [16:0] fade_plan [6];

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = KIND_UNUSED;
        i_table_index = '0;
        i_table_value = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_OCTAVE_COUNT;
        i_cfg_data = '0;
        stall_cycles = 0;
        beats = 0;
        idle_pct = 30;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every table first so no evaluate ever reads an unwritten entry
        for (int e = 0; e < PERM_DEPTH; e++)
            send_beat(KIND_PERM_WRITE, 11'(e), $urandom, $urandom, $urandom, $urandom);
        for (int e = 0; e < OFFSET_DEPTH; e++)
            send_beat(KIND_OFFSET_WRITE, 11'(e), $urandom, 0, 0, 0);

        // directed: reset config, coordinate extremes, ignored beats
        evaluate(32'h0, 32'h0, 32'h0);
        evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        evaluate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        evaluate(32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF);
        evaluate(32'h0000_8000, 32'h0001_0000, 32'h0000_0001);
        send_beat(KIND_UNUSED, 11'h7FF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_beat(KIND_OFFSET_WRITE, 11'd24, 32'h1234_5678, 0, 0, 0);
        send_beat(KIND_OFFSET_WRITE, 11'h7FF, 32'hFFFF_FFFF, 0, 0, 0);
        send_beat(KIND_PERM_WRITE, 11'h7FF, 32'hFFFF_FFFF, 0, 0, 0);
        send_beat(KIND_OFFSET_WRITE, 11'd0, 32'h7FFF_FFFF, 0, 0, 0);
        send_beat(KIND_OFFSET_WRITE, 11'd1, 32'h8000_0000, 0, 0, 0);
        evaluate(32'h0001_2345, 32'hFFFE_DCBA, 32'h0000_0000);
        evaluate(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);

        // octave count zero acts as one; fade weight set to zero as well
        quiesce();
        write_cfg(CFG_OCTAVE_COUNT, 17'd0);
        write_cfg(CFG_FADE_WEIGHT, 17'd0);
        evaluate(32'h0003_1234, 32'h0001_0000, 32'hFFF0_8000);
        // count beyond the octave limit saturates, fade above one saturates
        quiesce();
        write_cfg(CFG_OCTAVE_COUNT, 17'h1_FFFF);
        write_cfg(CFG_FADE_WEIGHT, 17'h1_FFFF);
        evaluate(32'h0000_4000, 32'h0020_0000, 32'hFFFF_C000);
        // fade of exactly one: weight sum is plain count
        quiesce();
        write_cfg(CFG_FADE_WEIGHT, 17'd65536);
        evaluate(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000);

        // random phases, each with its own register setting
        octave_plan = '{4'd1, 4'd3, 4'd8, 4'd15, 4'd0, 4'd5};
        fade_plan = '{17'd32768, 17'd20000, 17'd65536, 17'h1_FFFF, 17'd1, 17'd45000};
        for (int p = 0; p < 6; p++) begin
            quiesce();
            write_cfg(CFG_OCTAVE_COUNT, 17'(octave_plan[p]));
            write_cfg(CFG_FADE_WEIGHT, fade_plan[p]);
            idle_pct = (p < 2) ? 30 : (p < 4) ? 79 : 0;
            for (int n = 0; n < 165; n++) random_beat();
        end

        quiesce();
        $display("%0d command beats, %0d evaluates, %0d results; six register settings",
                 beats, evaluates, results);
        $display("including zero and saturated octave count and fade weight extremes");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/ogn_pkg.sv
src/ogn_ram.sv
src/ogn_div.sv
src/octave_gradient_noise_3d_unit.sv
tb/ogn_tb_pkg.sv
tb/octave_gradient_noise_3d_checker.sv
tb/octave_gradient_noise_3d_unit_test.sv
